### rtl/core/rdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdh_pkg;

  // field widths
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned SENS_W = 7;
  localparam int unsigned REM_W  = 6;
  localparam int unsigned NUM_W  = 14;
  localparam int unsigned QH_W   = 4;
  localparam int unsigned BAND_W = 9;

  // sensitivity limits
  localparam logic [SENS_W-1:0] SENS_RESET = 7'd16;
  localparam logic [SENS_W-1:0] SENS_MIN   = 7'd1;
  localparam logic [SENS_W-1:0] SENS_MAX   = 7'd64;

  // full-scale channel value
  localparam logic [PIX_W-1:0] FULL = 8'd255;

  // divide by three as multiply by 683 and shift right by 11 (exact for sums up to 765)
  localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
  localparam int unsigned      DIV3_SHIFT = 11;

  // colour ramp bands
  typedef enum logic [2:0] {
    BAND_BLUE,
    BAND_GREEN,
    BAND_YELLOW,
    BAND_RED,
    BAND_SAT
  } band_e;

  // input pixel pair
  typedef struct packed {
    logic [PIX_W-1:0] a_red;
    logic [PIX_W-1:0] a_green;
    logic [PIX_W-1:0] a_blue;
    logic [PIX_W-1:0] b_red;
    logic [PIX_W-1:0] b_green;
    logic [PIX_W-1:0] b_blue;
  } pix_in_t;

  // heatmap result
  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] diff_level;
  } pix_out_t;

  // level stage to band stage
  typedef struct packed {
    logic [PIX_W-1:0] d;
  } level_t;

  // band stage to ramp stages
  typedef struct packed {
    logic [PIX_W-1:0] d;
    band_e            band;
    logic [NUM_W-1:0] num;
  } band_t;

  // pipeline handshake between stages
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

  // one restoring division step: returns {quotient bit, new partial remainder}
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0]  p,
                                              input logic              nbit,
                                              input logic [SENS_W-1:0] s);
    logic [REM_W:0] sh;
    logic [REM_W:0] diff;
    sh   = {p, nbit};
    diff = sh - s;
    if (sh >= s) begin
      return {1'b1, diff[REM_W-1:0]};
    end
    return {1'b0, sh[REM_W-1:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/rdh_level.sv
`timescale 1ns / 1ps
`default_nettype none

// absolute channel differences and their mean, two register stages
module rdh_level (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rdh_pkg::pix_in_t data_i,
  output rdh_pkg::hs_t         hs_o,
  input  wire logic            ready_i,
  output rdh_pkg::level_t      data_o
);

  logic                        s1_valid_q;
  logic                        s1_ready;
  logic [rdh_pkg::SUM_W-1:0]   sum_d, sum_q;
  logic                        s2_valid_q;
  logic                        s2_ready;
  logic [2*rdh_pkg::SUM_W-1:0] prod;
  logic [rdh_pkg::PIX_W-1:0]   d_q;
  logic [rdh_pkg::PIX_W-1:0]   dr, dg, db;

  // absolute differences per channel
  always_comb begin
    dr = (data_i.a_red > data_i.b_red) ? data_i.a_red - data_i.b_red
                                       : data_i.b_red - data_i.a_red;
    dg = (data_i.a_green > data_i.b_green) ? data_i.a_green - data_i.b_green
                                           : data_i.b_green - data_i.a_green;
    db = (data_i.a_blue > data_i.b_blue) ? data_i.a_blue - data_i.b_blue
                                         : data_i.b_blue - data_i.a_blue;
    sum_d = rdh_pkg::SUM_W'(dr) + rdh_pkg::SUM_W'(dg) + rdh_pkg::SUM_W'(db);
  end

  // stage handshake
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s2_ready = !s2_valid_q || ready_i;
  assign ready_o  = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // stage 1: channel sum
  always_ff @(posedge clk_i) begin
    if (valid_i && s1_ready) begin
      sum_q <= sum_d;
    end
  end

  // stage 2: mean by reciprocal multiply
  assign prod = sum_q * rdh_pkg::DIV3_MUL;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      d_q <= prod[rdh_pkg::DIV3_SHIFT +: rdh_pkg::PIX_W];
    end
  end

  assign hs_o.valid = s2_valid_q;
  assign hs_o.ready = s1_ready;
  assign data_o.d   = d_q;

endmodule

`default_nettype wire

### rtl/core/rdh_band.sv
`timescale 1ns / 1ps
`default_nettype none

// band select and remainder within the band, one register stage
module rdh_band (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rdh_pkg::SENS_W-1:0]  sens_i,
  input  wire rdh_pkg::hs_t                hs_i,
  output logic                             ready_o,
  input  wire rdh_pkg::level_t             data_i,
  output logic                             valid_o,
  input  wire logic                        ready_i,
  output rdh_pkg::band_t                   data_o
);

  logic                         valid_q;
  logic                         ready;
  rdh_pkg::band_t               band_d, band_q;
  logic [rdh_pkg::BAND_W-1:0]   s1, s2, s3, s4, d9, rem9;
  logic [rdh_pkg::REM_W-1:0]    rem;

  // band edges at s, 2s, 3s, 4s
  always_comb begin
    s1   = rdh_pkg::BAND_W'(sens_i);
    s2   = rdh_pkg::BAND_W'({sens_i, 1'b0});
    s3   = s1 + s2;
    s4   = rdh_pkg::BAND_W'({sens_i, 2'b00});
    d9   = rdh_pkg::BAND_W'(data_i.d);
    rem9 = '0;
    band_d.band = rdh_pkg::BAND_SAT;
    if (d9 < s1) begin
      band_d.band = rdh_pkg::BAND_BLUE;
      rem9 = d9;
    end else if (d9 < s2) begin
      band_d.band = rdh_pkg::BAND_GREEN;
      rem9 = d9 - s1;
    end else if (d9 < s3) begin
      band_d.band = rdh_pkg::BAND_YELLOW;
      rem9 = d9 - s2;
    end else if (d9 < s4) begin
      band_d.band = rdh_pkg::BAND_RED;
      rem9 = d9 - s3;
    end
    rem = rem9[rdh_pkg::REM_W-1:0];
    // remainder times 255
    band_d.num = rdh_pkg::NUM_W'({rem, 8'h00}) - rdh_pkg::NUM_W'(rem);
    band_d.d   = data_i.d;
  end

  // stage handshake
  assign ready   = !valid_q || ready_i;
  assign ready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= hs_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_i.valid && ready) begin
      band_q <= band_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = band_q;

  // the divider needs its first partial remainder below the divisor
  a_num_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ({1'b0, band_q.num[rdh_pkg::NUM_W-1:8]} < sens_i))
    else $error("band remainder out of range");

endmodule

`default_nettype wire

### rtl/core/rdh_ramp.sv
`timescale 1ns / 1ps
`default_nettype none

// ramp position by two-stage restoring division, then colour lookup
module rdh_ramp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rdh_pkg::SENS_W-1:0] sens_i,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire rdh_pkg::band_t             data_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output rdh_pkg::pix_out_t               data_o
);

  logic                        s4_valid_q, s4_ready;
  logic                        s5_valid_q, s5_ready;
  logic [rdh_pkg::PIX_W-1:0]   d4_q;
  rdh_pkg::band_e              band4_q;
  logic [rdh_pkg::REM_W-1:0]   p4_d, p4_q;
  logic [rdh_pkg::QH_W-1:0]    qh_d, qh_q;
  logic [rdh_pkg::QH_W-1:0]    nlo_q;
  logic [rdh_pkg::QH_W-1:0]    ql;
  logic [rdh_pkg::REM_W-1:0]   p5;
  logic [rdh_pkg::REM_W:0]     st4, st5;
  logic [rdh_pkg::PIX_W-1:0]   t;
  rdh_pkg::pix_out_t           out_d, out_q;

  // upper four quotient bits
  always_comb begin
    p4_d = data_i.num[rdh_pkg::NUM_W-1:8];
    qh_d = '0;
    st4  = '0;
    for (int i = 0; i < rdh_pkg::QH_W; i++) begin
      st4  = rdh_pkg::div_step(p4_d, data_i.num[7-i], sens_i);
      qh_d[rdh_pkg::QH_W-1-i] = st4[rdh_pkg::REM_W];
      p4_d = st4[rdh_pkg::REM_W-1:0];
    end
  end

  // lower four quotient bits
  always_comb begin
    p5  = p4_q;
    ql  = '0;
    st5 = '0;
    for (int i = 0; i < rdh_pkg::QH_W; i++) begin
      st5 = rdh_pkg::div_step(p5, nlo_q[rdh_pkg::QH_W-1-i], sens_i);
      ql[rdh_pkg::QH_W-1-i] = st5[rdh_pkg::REM_W];
      p5  = st5[rdh_pkg::REM_W-1:0];
    end
    t = {qh_q, ql};
  end

  // colour per band
  always_comb begin
    out_d.diff_level = d4_q;
    case (band4_q)
      rdh_pkg::BAND_BLUE: begin
        out_d.out_red   = '0;
        out_d.out_green = '0;
        out_d.out_blue  = t;
      end
      rdh_pkg::BAND_GREEN: begin
        out_d.out_red   = '0;
        out_d.out_green = t;
        out_d.out_blue  = rdh_pkg::FULL - t;
      end
      rdh_pkg::BAND_YELLOW: begin
        out_d.out_red   = t;
        out_d.out_green = rdh_pkg::FULL;
        out_d.out_blue  = '0;
      end
      rdh_pkg::BAND_RED: begin
        out_d.out_red   = rdh_pkg::FULL;
        out_d.out_green = rdh_pkg::FULL - t;
        out_d.out_blue  = '0;
      end
      default: begin
        out_d.out_red   = rdh_pkg::FULL;
        out_d.out_green = '0;
        out_d.out_blue  = '0;
      end
    endcase
  end

  // stage handshake
  assign s4_ready = !s4_valid_q || s5_ready;
  assign s5_ready = !s5_valid_q || ready_i;
  assign ready_o  = s4_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_valid_q <= valid_i;
      end
      if (s5_ready) begin
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && s4_ready) begin
      d4_q    <= data_i.d;
      band4_q <= data_i.band;
      p4_q    <= p4_d;
      qh_q    <= qh_d;
      nlo_q   <= data_i.num[rdh_pkg::QH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q && s5_ready) begin
      out_q <= out_d;
    end
  end

  assign valid_o = s5_valid_q;
  assign data_o  = out_q;

  // partial remainder stays below the divisor
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> ({1'b0, p4_q} < sens_i))
    else $error("partial remainder not below divisor");

  // pure red only appears at or above four bands
  a_sat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_valid_q && out_q.out_red == rdh_pkg::FULL && out_q.out_green == '0 &&
     out_q.out_blue == '0)
    |-> ({1'b0, out_q.diff_level} >= {sens_i, 2'b00}))
    else $error("saturated red below four bands");

endmodule

`default_nettype wire

### rtl/core/rgb_difference_heatmap.sv
`timescale 1ns / 1ps
`default_nettype none

// Difference heatmap: each transfer on the input carries one pixel from each of two
// images; each output transfer carries the false-colour pixel and the mean absolute
// difference level d. One pixel pair is taken every clock unless the output stalls, and
// results pass five register stages (channel sum, divide by three, band select, two
// halves of an eight-step restoring divider); stall from the output holds the pipeline,
// and empty stages still take new pixels. Sensitivity is to be written with cfg_we_i only
// while the pipeline is empty, which the block does not enforce; 0 is taken as 1 and values above 64 as 64.
module rgb_difference_heatmap (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire rdh_pkg::pix_in_t           in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output rdh_pkg::pix_out_t               out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [rdh_pkg::SENS_W-1:0] cfg_wdata_i
);

  logic [rdh_pkg::SENS_W-1:0] sens_d, sens_q;
  logic                       lvl_ready;
  rdh_pkg::hs_t               lvl_hs;
  rdh_pkg::level_t            lvl_data;
  logic                       band_ready, band_valid;
  rdh_pkg::band_t             band_data;
  logic                       ramp_ready;

  // sensitivity register, clamped on write
  always_comb begin
    if (cfg_wdata_i == '0) begin
      sens_d = rdh_pkg::SENS_MIN;
    end else if (cfg_wdata_i > rdh_pkg::SENS_MAX) begin
      sens_d = rdh_pkg::SENS_MAX;
    end else begin
      sens_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q <= rdh_pkg::SENS_RESET;
    end else if (cfg_we_i) begin
      sens_q <= sens_d;
    end
  end

  // difference level
  rdh_level u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (lvl_ready),
    .data_i  (in_data_i),
    .hs_o    (lvl_hs),
    .ready_i (band_ready),
    .data_o  (lvl_data)
  );

  // band select
  rdh_band u_band (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sens_i  (sens_q),
    .hs_i    (lvl_hs),
    .ready_o (band_ready),
    .data_i  (lvl_data),
    .valid_o (band_valid),
    .ready_i (ramp_ready),
    .data_o  (band_data)
  );

  // ramp position and colour
  rdh_ramp u_ramp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sens_i  (sens_q),
    .valid_i (band_valid),
    .ready_o (ramp_ready),
    .data_i  (band_data),
    .valid_o (out_valid_o),
    .ready_i (!out_stall_i),
    .data_o  (out_data_o)
  );

  assign in_stall_o = !lvl_ready;

  // effective sensitivity always within the band range
  a_sens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sens_q != '0) && (sens_q <= rdh_pkg::SENS_MAX))
    else $error("sensitivity out of range");

  // an empty output stage never holds off the input
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // the level stage handshake view matches its ready
  a_lvl_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_hs.valid && !band_ready) |-> (in_stall_o == lvl_hs.valid && !lvl_ready) ||
    !in_stall_o)
    else $error("level stage ready mismatch");

endmodule

`default_nettype wire

### dv/tb_rgb_difference_heatmap.sv
`timescale 1ns / 1ps

module tb_rgb_difference_heatmap;

  localparam int unsigned LIMIT_NS = 4_000_000;

  // one directed row: register value, pixel pair, and a typed-in result where obvious
  typedef struct {
    logic [rdh_pkg::SENS_W-1:0] sens;
    rdh_pkg::pix_in_t           pix;
    bit                         lit;
    rdh_pkg::pix_out_t          want;
  } dir_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid;
  logic                       in_stall;
  rdh_pkg::pix_in_t           in_data;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  rdh_pkg::pix_out_t          out_data;
  logic                       cfg_we;
  logic [rdh_pkg::SENS_W-1:0] cfg_wdata;

  rdh_pkg::pix_out_t          heat_q [$];
  dir_row_t                   dir_rows [$];
  logic [rdh_pkg::SENS_W-1:0] sens_shadow;
  int                         err_count = 0;
  int unsigned                burst_left = 0;
  string                      fld_name [4] = '{"diff_level", "out_blue", "out_green",
                                               "out_red"};

  rgb_difference_heatmap u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned abs_gap(input logic [rdh_pkg::PIX_W-1:0] x,
                                          input logic [rdh_pkg::PIX_W-1:0] y);
    return (x > y) ? 32'(x - y) : 32'(y - x);
  endfunction

  // heatmap colour and level for one pixel pair under a register value
  function automatic rdh_pkg::pix_out_t predict_heat(input rdh_pkg::pix_in_t p,
                                                     input logic [rdh_pkg::SENS_W-1:0] reg_val);
    int unsigned       d;
    int unsigned       s;
    int unsigned       band;
    int unsigned       t;
    rdh_pkg::band_e    sel;
    rdh_pkg::pix_out_t r;
    d = (abs_gap(p.a_red, p.b_red) + abs_gap(p.a_green, p.b_green) +
         abs_gap(p.a_blue, p.b_blue)) / 3;
    s = 32'(reg_val);
    if (s < 32'(rdh_pkg::SENS_MIN)) s = 32'(rdh_pkg::SENS_MIN);
    if (s > 32'(rdh_pkg::SENS_MAX)) s = 32'(rdh_pkg::SENS_MAX);
    band = d / s;
    t = ((d - band * s) * 32'(rdh_pkg::FULL)) / s;
    sel = (band >= 4) ? rdh_pkg::BAND_SAT : rdh_pkg::band_e'(band[2:0]);
    r.diff_level = d[rdh_pkg::PIX_W-1:0];
    case (sel)
      rdh_pkg::BAND_BLUE: begin
        r.out_red   = '0;
        r.out_green = '0;
        r.out_blue  = t[rdh_pkg::PIX_W-1:0];
      end
      rdh_pkg::BAND_GREEN: begin
        r.out_red   = '0;
        r.out_green = t[rdh_pkg::PIX_W-1:0];
        r.out_blue  = rdh_pkg::FULL - t[rdh_pkg::PIX_W-1:0];
      end
      rdh_pkg::BAND_YELLOW: begin
        r.out_red   = t[rdh_pkg::PIX_W-1:0];
        r.out_green = rdh_pkg::FULL;
        r.out_blue  = '0;
      end
      rdh_pkg::BAND_RED: begin
        r.out_red   = rdh_pkg::FULL;
        r.out_green = rdh_pkg::FULL - t[rdh_pkg::PIX_W-1:0];
        r.out_blue  = '0;
      end
      default: begin
        r.out_red   = rdh_pkg::FULL;
        r.out_green = '0;
        r.out_blue  = '0;
      end
    endcase
    return r;
  endfunction

  function automatic rdh_pkg::pix_in_t mk_pix(input int ar, input int ag, input int ab,
                                              input int br, input int bg, input int bb);
    rdh_pkg::pix_in_t p;
    p.a_red = ar[7:0]; p.a_green = ag[7:0]; p.a_blue = ab[7:0];
    p.b_red = br[7:0]; p.b_green = bg[7:0]; p.b_blue = bb[7:0];
    return p;
  endfunction

  function automatic rdh_pkg::pix_out_t mk_out(input int r, input int g, input int b,
                                               input int d);
    rdh_pkg::pix_out_t o;
    o.out_red = r[7:0]; o.out_green = g[7:0]; o.out_blue = b[7:0]; o.diff_level = d[7:0];
    return o;
  endfunction

  // two channel values that differ by exactly gap, in random order
  task automatic near_pair(input int unsigned gap, output logic [rdh_pkg::PIX_W-1:0] x,
                           output logic [rdh_pkg::PIX_W-1:0] y);
    logic [rdh_pkg::PIX_W-1:0] lo;
    lo = 8'($urandom_range(0, 32'(rdh_pkg::FULL) - gap));
    if ($urandom_range(0, 1)) begin
      x = lo; y = lo + gap[7:0];
    end else begin
      y = lo; x = lo + gap[7:0];
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  // one input transfer, with a random gap between bursts; called at a falling edge
  task automatic send_pixel(input rdh_pkg::pix_in_t p, input bit lit,
                            input rdh_pkg::pix_out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    heat_q.push_back(lit ? want : predict_heat(p, sens_shadow));
    @(negedge clk_i);
  endtask

  // drain the pipeline, then write the sensitivity register
  task automatic set_sensitivity(input logic [rdh_pkg::SENS_W-1:0] val);
    in_valid <= 1'b0;
    while (heat_q.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    sens_shadow = val;
    burst_left = 0;
  endtask

  // random pixel pair, half the time aimed across the colour bands of the current setting
  task automatic random_pixel(output rdh_pkg::pix_in_t p);
    int unsigned s;
    int unsigned target;
    int unsigned kind;
    logic [63:0] rnd;
    s = 32'(sens_shadow);
    if (s < 32'(rdh_pkg::SENS_MIN)) s = 32'(rdh_pkg::SENS_MIN);
    if (s > 32'(rdh_pkg::SENS_MAX)) s = 32'(rdh_pkg::SENS_MAX);
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      rnd = {$urandom(), $urandom()};
      p = rnd[47:0];
    end else if (kind < 9) begin
      target = $urandom_range(0, 4 * s + 8);
      if (target > 253) target = 253;
      near_pair(target + $urandom_range(0, 2), p.a_red, p.b_red);
      near_pair(target + $urandom_range(0, 2), p.a_green, p.b_green);
      near_pair(target + $urandom_range(0, 2), p.a_blue, p.b_blue);
    end else begin
      p.a_red = 8'($urandom()); p.a_green = 8'($urandom()); p.a_blue = 8'($urandom());
      p.b_red = p.a_red;        p.b_green = p.a_green;      p.b_blue = p.a_blue;
    end
  endtask

  // receiver stall pattern, switching to a random mode after each run of random length
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_cyc  = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_cyc % 7 < 3);
    endcase
  end

  // compare each output transfer with the oldest expected pixel
  always @(posedge clk_i) begin
    rdh_pkg::pix_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (heat_q.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing expected", out_data));
      end else begin
        want = heat_q.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (out_data[i*rdh_pkg::PIX_W +: rdh_pkg::PIX_W] !==
              want[i*rdh_pkg::PIX_W +: rdh_pkg::PIX_W]) begin
            report_mismatch($sformatf("%s got %0d want %0d", fld_name[i],
                                      out_data[i*rdh_pkg::PIX_W +: rdh_pkg::PIX_W],
                                      want[i*rdh_pkg::PIX_W +: rdh_pkg::PIX_W]));
          end
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_rgb_difference_heatmap: errors");
    $finish;
  end

  initial begin
    rdh_pkg::pix_in_t           p;
    logic [rdh_pkg::SENS_W-1:0] phase_sens [8];
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    sens_shadow = rdh_pkg::SENS_RESET;

    // reset value, extremes, truncation of the mean
    dir_rows.push_back('{7'd16, mk_pix(0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0)});
    dir_rows.push_back('{7'd16, mk_pix(255, 255, 255, 0, 0, 0), 1'b1, mk_out(255, 0, 0, 255)});
    dir_rows.push_back('{7'd16, mk_pix(0, 0, 0, 255, 255, 255), 1'b1, mk_out(255, 0, 0, 255)});
    dir_rows.push_back('{7'd16, mk_pix(48, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 255, 16)});
    dir_rows.push_back('{7'd16, mk_pix(0, 0, 0, 0, 0, 100), 1'b0, '0});
    dir_rows.push_back('{7'd16, mk_pix(150, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd16, mk_pix(189, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd16, mk_pix(192, 0, 0, 0, 0, 0), 1'b1, mk_out(255, 0, 0, 64)});
    dir_rows.push_back('{7'd16, mk_pix(255, 128, 0, 0, 128, 255), 1'b0, '0});
    dir_rows.push_back('{7'd16, mk_pix(0, 3, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd16, mk_pix(2, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0)});
    // zero register value acts as one: each level is its own band
    dir_rows.push_back('{7'd0, mk_pix(0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 0)});
    dir_rows.push_back('{7'd0, mk_pix(3, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 255, 1)});
    dir_rows.push_back('{7'd0, mk_pix(0, 6, 0, 0, 0, 0), 1'b1, mk_out(0, 255, 0, 2)});
    dir_rows.push_back('{7'd0, mk_pix(0, 0, 0, 0, 0, 9), 1'b1, mk_out(255, 255, 0, 3)});
    dir_rows.push_back('{7'd0, mk_pix(12, 0, 0, 0, 0, 0), 1'b1, mk_out(255, 0, 0, 4)});
    dir_rows.push_back('{7'd1, mk_pix(255, 255, 255, 0, 0, 0), 1'b1, mk_out(255, 0, 0, 255)});
    dir_rows.push_back('{7'd64, mk_pix(255, 255, 255, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd64, mk_pix(100, 100, 100, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd64, mk_pix(0, 0, 0, 32, 32, 32), 1'b0, '0});
    // register above range acts as the widest band
    dir_rows.push_back('{7'd65, mk_pix(255, 255, 255, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd127, mk_pix(200, 200, 200, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{7'd127, mk_pix(0, 0, 0, 255, 255, 0), 1'b0, '0});

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].sens != sens_shadow) set_sensitivity(dir_rows[i].sens);
      send_pixel(dir_rows[i].pix, dir_rows[i].lit, dir_rows[i].want);
    end

    // random phases, each under its own register value
    phase_sens = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd16, 7'd0, 7'd0};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph >= 6) phase_sens[ph] = 7'($urandom_range(2, 63));
      set_sensitivity(phase_sens[ph]);
      for (int n = 0; n < 155; n++) begin
        random_pixel(p);
        send_pixel(p, 1'b0, '0);
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    while (heat_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_rgb_difference_heatmap: clean");
    end else begin
      $display("tb_rgb_difference_heatmap: errors");
    end
    $finish;
  end

endmodule
